@@ hdl/rbsi_pkg.sv @@
// Package with widths, constants and types for the ray versus box slab test.
`default_nettype none
package rbsi_pkg;
    localparam int COORD_FRAC_BITS = 4;
    localparam int T_FRAC_BITS     = 16;

    // Field widths.
    localparam int COORD_W = 20;
    localparam int SIZE_W  = 19;
    localparam int T_W     = 17;

    // Edge offsets need two more bits than a coordinate; their magnitude one less.
    localparam int OFF_W = COORD_W + 2;
    localparam int MAG_W = OFF_W - 1;
    // Dividend magnitude and divisor magnitude.
    localparam int NUM_W = MAG_W + T_FRAC_BITS;
    localparam int DEN_W = COORD_W;
    // Signed slab bound width, wide enough for the saturation value.
    localparam int BND_W = 24 + T_FRAC_BITS;

    localparam logic signed [BND_W-1:0] SAT_T =
        BND_W'((64'd1 << (22 + T_FRAC_BITS)) - 64'd1);
    localparam logic signed [BND_W-1:0] T_ONE = BND_W'(64'd1 << T_FRAC_BITS);

    localparam int LANES = 4;

    // One divider lane as it moves through the pipeline.
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] nq;
        logic [DEN_W-1:0] den;
        logic             neg;
        logic             step_zero;
        logic             off_neg;
        logic             off_zero;
    } t_lane;

    // Step components carried beside the lanes for the normal.
    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
    } t_side;
endpackage
`default_nettype wire

@@ hdl/rbsi_in_if.sv @@
// Input channel interface: one segment and one box per transaction.
`default_nettype none
interface rbsi_in_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [rbsi_pkg::COORD_W-1:0]      origin_x;
    logic signed [rbsi_pkg::COORD_W-1:0]      origin_y;
    logic signed [rbsi_pkg::COORD_W-1:0]      step_x;
    logic signed [rbsi_pkg::COORD_W-1:0]      step_y;
    logic signed [rbsi_pkg::COORD_W-1:0]      box_x;
    logic signed [rbsi_pkg::COORD_W-1:0]      box_y;
    logic        [rbsi_pkg::SIZE_W-1:0]       box_w;
    logic        [rbsi_pkg::SIZE_W-1:0]       box_h;
    modport source (output valid, origin_x, origin_y, step_x, step_y, box_x, box_y,
                    box_w, box_h, input ready);
    modport sink (input valid, origin_x, origin_y, step_x, step_y, box_x, box_y,
                  box_w, box_h, output ready);
endinterface
`default_nettype wire

@@ hdl/rbsi_out_if.sv @@
// Output channel interface: one intersection result per transaction.
`default_nettype none
interface rbsi_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 hit;
    logic        [rbsi_pkg::T_W-1:0]      entry_t;
    logic signed [rbsi_pkg::COORD_W-1:0]  normal_x;
    logic signed [rbsi_pkg::COORD_W-1:0]  normal_y;
    modport source (output valid, hit, entry_t, normal_x, normal_y, input ready);
    modport sink (input valid, hit, entry_t, normal_x, normal_y, output ready);
endinterface
`default_nettype wire

@@ hdl/ray_box_slab_intersect.sv @@
// Top level: pipelined 2-D segment versus axis-aligned box slab test.
//
//  channel  | direction | contents
//  ---------+-----------+--------------------------------------------------
//  i_in     | sink      | origin, step, box corner and box size
//  o_out    | source    | hit, entry t, normal
//
// One transaction enters per cycle while the output is not held.
// The pipeline is built from four restoring dividers that resolve one quotient
// bit per stage (37 stages), plus input, bound, ordering and output stages.
// Reset clears all valid bits; payload registers are not reset.
// When the output is held, the whole pipeline freezes and nothing is lost.
`default_nettype none
module ray_box_slab_intersect (
    input  wire        i_clk,
    input  wire        i_rst_n,
    rbsi_in_if.sink    i_in,
    rbsi_out_if.source o_out
);
    localparam int NW = rbsi_pkg::NUM_W;
    localparam int DW = rbsi_pkg::DEN_W;
    localparam int BW = rbsi_pkg::BND_W;
    localparam int OW = rbsi_pkg::OFF_W;
    localparam int CW = rbsi_pkg::COORD_W;

    logic en;

    rbsi_pkg::t_lane r_lane [0:NW][0:rbsi_pkg::LANES-1];
    rbsi_pkg::t_side r_side [0:NW];
    logic            r_vld  [0:NW];

    // Pipeline advances whenever the output register is free or drained.
    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    // Input stage: edge offsets and magnitudes.
    logic signed [OW-1:0] off [0:rbsi_pkg::LANES-1];
    logic signed [OW-1:0] stp [0:rbsi_pkg::LANES-1];
    rbsi_pkg::t_lane      n_lane0 [0:rbsi_pkg::LANES-1];

    always_comb begin
        logic signed [OW-1:0] ox, oy, bx, by, bwx, bhy;
        ox  = OW'(i_in.origin_x);
        oy  = OW'(i_in.origin_y);
        bx  = OW'(i_in.box_x);
        by  = OW'(i_in.box_y);
        bwx = OW'({1'b0, i_in.box_w});
        bhy = OW'({1'b0, i_in.box_h});
        off[0] = bx - ox;
        off[1] = bx + bwx - ox;
        off[2] = by - oy;
        off[3] = by + bhy - oy;
        stp[0] = OW'(i_in.step_x);
        stp[1] = OW'(i_in.step_x);
        stp[2] = OW'(i_in.step_y);
        stp[3] = OW'(i_in.step_y);
        for (int l = 0; l < rbsi_pkg::LANES; l++) begin
            logic [OW-1:0] am, sm;
            am = off[l][OW-1] ? OW'(-off[l]) : OW'(off[l]);
            sm = stp[l][OW-1] ? OW'(-stp[l]) : OW'(stp[l]);
            n_lane0[l].rem       = '0;
            n_lane0[l].nq        = {am[rbsi_pkg::MAG_W-1:0],
                                    {rbsi_pkg::T_FRAC_BITS{1'b0}}};
            n_lane0[l].den       = sm[DW-1:0];
            n_lane0[l].neg       = off[l][OW-1] ^ stp[l][OW-1];
            n_lane0[l].step_zero = (stp[l] == '0);
            n_lane0[l].off_neg   = off[l][OW-1];
            n_lane0[l].off_zero  = (off[l] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < rbsi_pkg::LANES; l++) r_lane[0][l] <= n_lane0[l];
            r_side[0].sx <= i_in.step_x;
            r_side[0].sy <= i_in.step_y;
        end
    end

    // Divider stages: one quotient bit per stage in every lane.
    for (genvar k = 0; k < NW; k++) begin : g_div
        rbsi_pkg::t_lane n_lane [0:rbsi_pkg::LANES-1];

        always_comb begin
            for (int l = 0; l < rbsi_pkg::LANES; l++) begin
                logic [DW:0] trial;
                logic        ge;
                trial = {r_lane[k][l].rem, r_lane[k][l].nq[NW-1]};
                ge    = (trial >= {1'b0, r_lane[k][l].den});
                n_lane[l]     = r_lane[k][l];
                n_lane[l].rem = ge ? DW'(trial - {1'b0, r_lane[k][l].den}) : trial[DW-1:0];
                n_lane[l].nq  = {r_lane[k][l].nq[NW-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int l = 0; l < rbsi_pkg::LANES; l++) r_lane[k+1][l] <= n_lane[l];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    // Bound stage: floor rounding, sign and the zero step cases.
    logic signed [BW-1:0] n_bnd [0:rbsi_pkg::LANES-1];
    logic signed [BW-1:0] r_bnd [0:rbsi_pkg::LANES-1];
    rbsi_pkg::t_side      r_side_b;
    logic                 r_vld_b;

    always_comb begin
        for (int l = 0; l < rbsi_pkg::LANES; l++) begin
            logic signed [BW-1:0] q;
            q = BW'({1'b0, r_lane[NW][l].nq});
            if (r_lane[NW][l].step_zero) begin
                if (r_lane[NW][l].off_zero)     n_bnd[l] = '0;
                else if (r_lane[NW][l].off_neg) n_bnd[l] = -rbsi_pkg::SAT_T;
                else                            n_bnd[l] = rbsi_pkg::SAT_T;
            end else if (r_lane[NW][l].neg) begin
                n_bnd[l] = -q - BW'(r_lane[NW][l].rem != '0);
            end else begin
                n_bnd[l] = q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_b <= 1'b0;
        end else if (en) begin
            r_vld_b <= r_vld[NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < rbsi_pkg::LANES; l++) r_bnd[l] <= n_bnd[l];
            r_side_b <= r_side[NW];
        end
    end

    // Ordering stage: near and far bound per axis.
    logic signed [BW-1:0] r_nx, r_fx, r_ny, r_fy;
    rbsi_pkg::t_side      r_side_o;
    logic                 r_vld_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_o <= 1'b0;
        end else if (en) begin
            r_vld_o <= r_vld_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nx     <= (r_bnd[0] > r_bnd[1]) ? r_bnd[1] : r_bnd[0];
            r_fx     <= (r_bnd[0] > r_bnd[1]) ? r_bnd[0] : r_bnd[1];
            r_ny     <= (r_bnd[2] > r_bnd[3]) ? r_bnd[3] : r_bnd[2];
            r_fy     <= (r_bnd[2] > r_bnd[3]) ? r_bnd[2] : r_bnd[3];
            r_side_o <= r_side_b;
        end
    end

    // Output stage: overlap test, entry selection and range check.
    logic                 n_hit;
    logic [rbsi_pkg::T_W-1:0] n_t;
    logic signed [CW-1:0] n_nx, n_ny;
    logic                 r_out_vld, r_hit;
    logic [rbsi_pkg::T_W-1:0] r_t;
    logic signed [CW-1:0] r_onx, r_ony;

    always_comb begin
        logic                 miss, on_y;
        logic signed [BW-1:0] t;
        miss  = (r_nx > r_fy) || (r_ny > r_fx);
        on_y  = (r_nx < r_ny);
        t     = on_y ? r_ny : r_nx;
        n_hit = !miss && (t >= 0) && (t <= rbsi_pkg::T_ONE);
        n_t   = n_hit ? t[rbsi_pkg::T_W-1:0] : '0;
        n_nx  = (n_hit && !on_y) ? CW'(-r_side_o.sx) : '0;
        n_ny  = (n_hit && on_y)  ? CW'(-r_side_o.sy) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld_o;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit <= n_hit;
            r_t   <= n_t;
            r_onx <= n_nx;
            r_ony <= n_ny;
        end
    end

    assign o_out.valid    = r_out_vld;
    assign o_out.hit      = r_hit;
    assign o_out.entry_t  = r_t;
    assign o_out.normal_x = r_onx;
    assign o_out.normal_y = r_ony;

`ifndef ASSERT_OFF
    // Nothing is presented right after reset.
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

    // A miss carries all zero fields.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.hit) |->
        (o_out.entry_t == '0 && o_out.normal_x == '0 && o_out.normal_y == '0))
        else $error("miss with nonzero fields");

    // The entry lies on only one slab.
    a_one_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.normal_x == '0 || o_out.normal_y == '0))
        else $error("normal on both axes");

    // A held result stays valid, with hit and entry t unchanged, while the pipeline is frozen.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=>
        (o_out.valid && $stable(o_out.hit) && $stable(o_out.entry_t)))
        else $error("result dropped during stall");
`endif
endmodule
`default_nettype wire
